// ===== hdl/input_report_ring_queue_assert.svh =====
`ifndef INPUT_REPORT_RING_QUEUE_ASSERT_SVH
`define INPUT_REPORT_RING_QUEUE_ASSERT_SVH

// same-cycle implication
`define ILQ_ASSERT_IMPLY(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("ring queue check failed");

// delayed implication
`define ILQ_ASSERT_LAT2(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##2 (c)) \
    else $error("ring queue latency check failed");

`endif

// ===== hdl/ilq_pkg.sv =====
package ilq_pkg;

  localparam int QUEUE_DEPTH_DEF  = 256;
  localparam int MAX_DEVICES_DEF  = 16;
  localparam int REPORT_BYTES_DEF = 8;

  localparam int PAYLOAD_BYTES = 8;
  localparam int OUT_DEV_W     = 5;
  localparam int OUT_SIZE_W    = 4;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_ERROR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [31:0] ERROR_FLAG_RESET = 32'd1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  device_id;
    logic [7:0]  report_size;
    logic [31:0] report_flags;
    logic [63:0] report_payload;
    logic [63:0] now_tick;
  } in_item_t;

  typedef struct packed {
    status_t                 status;
    logic [OUT_DEV_W-1:0]    out_device;
    logic [OUT_SIZE_W-1:0]   out_size;
    logic [31:0]             out_flags;
    logic [31:0]             out_lost;
    logic [63:0]             out_tick;
    logic [63:0]             out_payload;
  } out_item_t;

  typedef struct packed {
    logic [OUT_DEV_W-1:0]  device;
    logic [OUT_SIZE_W-1:0] size;
    logic [31:0]           flags;
    logic [31:0]           lost;
    logic [63:0]           tick;
    logic [63:0]           payload;
  } slot_t;

  function automatic logic [63:0] mask_payload(logic [63:0] payload, logic [7:0] size);
    logic [63:0] res;
    res = '0;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      if (8'(i) < size) res[i*8 +: 8] = payload[i*8 +: 8];
    end
    return res;
  endfunction

endpackage

// ===== hdl/ilq_slot_ram.sv =====
module ilq_slot_ram #(
  parameter int DEPTH = ilq_pkg::QUEUE_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  ilq_pkg::slot_t wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output ilq_pkg::slot_t rd_data
);

  ilq_pkg::slot_t mem [DEPTH];
  ilq_pkg::slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/ilq_loss_bank.sv =====
module ilq_loss_bank #(
  parameter int MAX_DEVICES = ilq_pkg::MAX_DEVICES_DEF,
  localparam int DW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [DW-1:0] dev_idx,
  input  logic          upd_en,
  input  logic [1:0]    upd_amt,
  output logic [31:0]   cur_cnt
);

  logic [31:0] cnt_r [MAX_DEVICES];
  logic [31:0] cnt_nxt;

  assign cur_cnt = cnt_r[dev_idx];
  assign cnt_nxt = cur_cnt + 32'(upd_amt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_DEVICES; i++) cnt_r[i] <= '0;
    end else if (upd_en) begin
      cnt_r[dev_idx] <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/input_report_ring_queue.sv =====
// Channel   Handshake              Beat
// input     start && !busy         in_data   (ilq_pkg::in_item_t)
// result    out_valid, one cycle   out_data  (ilq_pkg::out_item_t)
// config    cfg_valid && cfg_ready cfg_data  (error flag word)
//
// One beat per cycle is accepted while busy is low; each accepted beat yields one result strobe.
// The latency is the input register plus the registered read port of the slot memory.
// Reset is synchronous; busy is held high in reset and is cleared by its register once reset is released.
// The receiver cannot stall: every result is shown for exactly one cycle.
module input_report_ring_queue #(
  parameter int QUEUE_DEPTH  = ilq_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_DEVICES  = ilq_pkg::MAX_DEVICES_DEF,
  parameter int REPORT_BYTES = ilq_pkg::REPORT_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ilq_pkg::in_item_t  in_data,
  output logic               out_valid,
  output ilq_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);

`include "input_report_ring_queue_assert.svh"

  localparam int AW     = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = AW + 1;
  localparam int DW     = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;

  logic              busy_r;
  logic [31:0]       err_flags_r;
  logic              valid1_r;
  ilq_pkg::in_item_t item1_r;
  logic [AW-1:0]     head_r, head_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              out_valid_r;
  ilq_pkg::status_t  status_r, status_nxt;
  logic              pop_r;

  logic              dev_ok, size_ok, full;
  logic [DW-1:0]     dev_idx;
  logic [FILL_W-1:0] tail_sum;
  logic [AW-1:0]     tail;
  logic              wr_en, rd_en;
  logic              upd_en;
  logic [1:0]        upd_amt;
  logic [31:0]       cur_cnt;
  ilq_pkg::slot_t    wr_slot;
  ilq_pkg::slot_t    rd_slot;

  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      err_flags_r <= ilq_pkg::ERROR_FLAG_RESET;
      valid1_r    <= 1'b0;
      head_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      status_r    <= ilq_pkg::ST_OK;
      pop_r       <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      if (cfg_valid && cfg_ready) err_flags_r <= cfg_data;
      valid1_r    <= start && !busy_r;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= valid1_r;
      status_r    <= status_nxt;
      pop_r       <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) item1_r <= in_data;
  end

  assign dev_ok  = (item1_r.device_id != 8'd0) && (item1_r.device_id <= 8'(MAX_DEVICES));
  assign size_ok = item1_r.report_size <= 8'(REPORT_BYTES);
  assign full    = fill_r == FILL_W'(QUEUE_DEPTH);
  assign dev_idx = DW'(item1_r.device_id - 8'd1);

  assign tail_sum = FILL_W'(head_r) + fill_r;
  assign tail     = (tail_sum >= FILL_W'(QUEUE_DEPTH)) ?
                    AW'(tail_sum - FILL_W'(QUEUE_DEPTH)) : AW'(tail_sum);

  always_comb begin
    status_nxt = ilq_pkg::ST_INVALID;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    upd_en     = 1'b0;
    upd_amt    = 2'd0;
    wr_slot.device  = ilq_pkg::OUT_DEV_W'(item1_r.device_id);
    wr_slot.size    = ilq_pkg::OUT_SIZE_W'(item1_r.report_size);
    wr_slot.flags   = item1_r.report_flags;
    wr_slot.lost    = cur_cnt;
    wr_slot.tick    = item1_r.now_tick;
    wr_slot.payload = ilq_pkg::mask_payload(item1_r.report_payload, item1_r.report_size);
    if (valid1_r) begin
      unique case (item1_r.op)
        ilq_pkg::OP_PUSH: begin
          if (dev_ok && size_ok) begin
            if (full) begin
              status_nxt = ilq_pkg::ST_FULL;
              upd_en     = 1'b1;
              upd_amt    = 2'd1;
            end else begin
              status_nxt = ilq_pkg::ST_OK;
              wr_en      = 1'b1;
            end
          end
        end
        ilq_pkg::OP_ERROR: begin
          if (dev_ok) begin
            // bump once for the error, once more when the report is dropped
            upd_en          = 1'b1;
            upd_amt         = full ? 2'd2 : 2'd1;
            status_nxt      = full ? ilq_pkg::ST_FULL : ilq_pkg::ST_OK;
            wr_en           = !full;
            wr_slot.size    = '0;
            wr_slot.flags   = err_flags_r;
            wr_slot.lost    = cur_cnt + 32'd1;
            wr_slot.payload = '0;
          end
        end
        ilq_pkg::OP_READ: begin
          if (fill_r == '0) begin
            status_nxt = ilq_pkg::ST_EMPTY;
          end else begin
            status_nxt = ilq_pkg::ST_OK;
            rd_en      = 1'b1;
          end
        end
        default: status_nxt = ilq_pkg::ST_INVALID;
      endcase
    end
  end

  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (rd_en) begin
      head_nxt = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + AW'(1);
      fill_nxt = fill_r - FILL_W'(1);
    end else if (wr_en) begin
      fill_nxt = fill_r + FILL_W'(1);
    end
  end

  ilq_loss_bank #(
    .MAX_DEVICES(MAX_DEVICES)
  ) u_loss (
    .clk     (clk),
    .rst_n   (rst_n),
    .dev_idx (dev_idx),
    .upd_en  (upd_en),
    .upd_amt (upd_amt),
    .cur_cnt (cur_cnt)
  );

  ilq_slot_ram #(
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (wr_slot),
    .rd_en   (rd_en),
    .rd_addr (head_r),
    .rd_data (rd_slot)
  );

  assign out_valid            = out_valid_r;
  assign out_data.status      = status_r;
  assign out_data.out_device  = pop_r ? rd_slot.device  : '0;
  assign out_data.out_size    = pop_r ? rd_slot.size    : '0;
  assign out_data.out_flags   = pop_r ? rd_slot.flags   : '0;
  assign out_data.out_lost    = pop_r ? rd_slot.lost    : '0;
  assign out_data.out_tick    = pop_r ? rd_slot.tick    : '0;
  assign out_data.out_payload = pop_r ? rd_slot.payload : '0;

  `ILQ_ASSERT_IMPLY(a_fill_bound, clk, rst_n, 1'b1, fill_r <= FILL_W'(QUEUE_DEPTH))
  `ILQ_ASSERT_LAT2(a_result_latency, clk, rst_n, start && !busy, out_valid)
  `ILQ_ASSERT_IMPLY(a_empty_means_none, clk, rst_n, out_valid_r && status_r == ilq_pkg::ST_EMPTY, $past(fill_r) == '0)
  `ILQ_ASSERT_IMPLY(a_pop_is_ok, clk, rst_n, pop_r, out_valid_r && status_r == ilq_pkg::ST_OK)

endmodule
